[src/tpf_pkg.sv]
// Shared widths, reset values and register indexes for the temperature PWM fader.
package tpf_pkg;

   localparam int TEMP_W        = 14;
   localparam int PWM_W         = 8;
   localparam int PERIOD_W      = 16;
   localparam int FIELD_SENSORS = 4;
   localparam int MASK_W        = FIELD_SENSORS;
   localparam int PROD_W        = TEMP_W + PWM_W;
   localparam int STEP_W        = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int NUM_SENSORS_DEF = 4;

   localparam logic [TEMP_W-1:0]   LOW_TEMP_RST  = 14'd800;
   localparam logic [TEMP_W-1:0]   HIGH_TEMP_RST = 14'd2400;
   localparam logic [PWM_W-1:0]    LOW_PWM_RST   = 8'd0;
   localparam logic [PWM_W-1:0]    HIGH_PWM_RST  = 8'd255;
   localparam logic [PERIOD_W-1:0] HEATUP_RST    = 16'd15;
   localparam logic [PERIOD_W-1:0] COOLDOWN_RST  = 16'd60;
   localparam logic [PERIOD_W-1:0] FADING_RST    = 16'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_TEMP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_TEMP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_PWM   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_PWM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEATUP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COOLDOWN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FADING    = 3'd6;

endpackage

[src/tpf_channels.sv]
// Request and response channel interfaces of the temperature PWM fader.
interface tpf_req_if import tpf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEMP_W-1:0] temp_a;
   logic [TEMP_W-1:0] temp_b;
   logic [TEMP_W-1:0] temp_c;
   logic [TEMP_W-1:0] temp_d;
   logic [MASK_W-1:0] valid_mask;

   modport source (output valid, temp_a, temp_b, temp_c, temp_d, valid_mask, input ready);
   modport sink   (input valid, temp_a, temp_b, temp_c, temp_d, valid_mask, output ready);
endinterface

interface tpf_rsp_if import tpf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             polled;
   logic [PWM_W-1:0] pwm_out;
   logic             switch_on;
   logic             pwm_changed;
   logic             switch_changed;

   modport source (output valid, polled, pwm_out, switch_on, pwm_changed, switch_changed,
                   input ready);
   modport sink   (input valid, polled, pwm_out, switch_on, pwm_changed, switch_changed,
                   output ready);
endinterface

[src/temperature_to_pwm_fader.sv]
// Temperature to PWM fader: periodic poll, max-of-sensors, linear fade with serial mul/div.
//
//   channel   dir   handshake            payload
//   req_bus   in    valid/ready          temp_a..temp_d, valid_mask (one tick per beat)
//   rsp_bus   out   valid/ready          polled, pwm_out, switch_on, pwm_changed,
//                                        switch_changed (one beat per tick)
//   csr_*     in    csr_we               csr_index, csr_wdata (write only)
//
// A tick that does not poll goes from acceptance straight to the result load.
// A polling tick scans S = min(NUM_SENSORS, 4) readings, one reading per cycle, then
// decides; at either end of the range it goes on to the result, and while fading it
// runs an 8-step shift-add multiply and an 8-step restoring divide, one bit per cycle.
// req_bus.ready is high only in the idle state; the result register lets a new tick in
// while the previous result is still waiting on rsp_bus.ready.
// Synchronous active-high reset restores register defaults, countdown 15, PWM 0, switch off.
module temperature_to_pwm_fader import tpf_pkg::*; #(
   parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tpf_req_if.sink               req_bus,
   tpf_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // sensors beyond the four carried fields are never looked at
   localparam int SCAN_COUNT = (NUM_SENSORS < FIELD_SENSORS) ? NUM_SENSORS : FIELD_SENSORS;
   localparam logic [STEP_W-1:0] SCAN_LAST = STEP_W'(SCAN_COUNT - 1);
   localparam logic [STEP_W-1:0] BIT_LAST  = STEP_W'(PWM_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   // ---------------- configuration registers ----------------
   logic [TEMP_W-1:0]   low_temp_ff, high_temp_ff;
   logic [PWM_W-1:0]    low_pwm_ff, high_pwm_ff;
   logic [PERIOD_W-1:0] heatup_ff, cooldown_ff, fading_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_temp_ff  <= LOW_TEMP_RST;
         high_temp_ff <= HIGH_TEMP_RST;
         low_pwm_ff   <= LOW_PWM_RST;
         high_pwm_ff  <= HIGH_PWM_RST;
         heatup_ff    <= HEATUP_RST;
         cooldown_ff  <= COOLDOWN_RST;
         fading_ff    <= FADING_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_TEMP:  low_temp_ff  <= csr_wdata[TEMP_W-1:0];
            CSR_HIGH_TEMP: high_temp_ff <= csr_wdata[TEMP_W-1:0];
            CSR_LOW_PWM:   low_pwm_ff   <= csr_wdata[PWM_W-1:0];
            CSR_HIGH_PWM:  high_pwm_ff  <= csr_wdata[PWM_W-1:0];
            CSR_HEATUP:    heatup_ff    <= csr_wdata[PERIOD_W-1:0];
            CSR_COOLDOWN:  cooldown_ff  <= csr_wdata[PERIOD_W-1:0];
            CSR_FADING:    fading_ff    <= csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // inverted limits collapse onto the low value
   logic [TEMP_W-1:0] hi_temp;
   logic [PWM_W-1:0]  hi_pwm;
   assign hi_temp = (high_temp_ff < low_temp_ff) ? low_temp_ff : high_temp_ff;
   assign hi_pwm  = (high_pwm_ff < low_pwm_ff) ? low_pwm_ff : high_pwm_ff;

   // ---------------- datapath / control registers ----------------
   state_type           state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [PERIOD_W-1:0] countdown_ff, countdown_in;
   logic [PWM_W-1:0]    held_ff, held_in;
   logic                switch_ff, switch_in;

   logic [TEMP_W-1:0]   temp_ff [FIELD_SENSORS];
   logic [TEMP_W-1:0]   temp_in [FIELD_SENSORS];
   logic [MASK_W-1:0]   mask_ff, mask_in;
   logic [TEMP_W-1:0]   best_ff, best_in;

   logic                poll_ff, poll_in;
   logic [PWM_W-1:0]    next_pwm_ff, next_pwm_in;
   logic [TEMP_W-1:0]   mcand_ff, mcand_in;     // t - low_temp
   logic [PWM_W-1:0]    mplier_ff, mplier_in;   // hi_pwm - low_pwm, consumed msb first
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [TEMP_W-1:0]   div_ff, div_in;         // hi_temp - low_temp
   logic [TEMP_W-1:0]   rem_ff, rem_in;
   logic [PWM_W-1:0]    quo_ff, quo_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_polled_ff, rsp_polled_in;
   logic [PWM_W-1:0]    rsp_pwm_ff, rsp_pwm_in;
   logic                rsp_switch_ff, rsp_switch_in;
   logic                rsp_pchg_ff, rsp_pchg_in;
   logic                rsp_schg_ff, rsp_schg_in;

   logic                req_fire;
   logic                rsp_free;
   logic [PROD_W-1:0]   acc_next;
   logic [TEMP_W:0]     trial;
   logic                trial_ge;
   logic [PWM_W-1:0]    quo_next;
   logic                sw_on;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // one multiply step: shift accumulator, add multiplicand on the current multiplier bit
   assign acc_next = {acc_ff[PROD_W-2:0], 1'b0}
                   + (mplier_ff[PWM_W-1] ? PROD_W'(mcand_ff) : PROD_W'(0));
   // one restoring divide step
   assign trial    = {rem_ff, quo_ff[PWM_W-1]};
   assign trial_ge = trial >= {1'b0, div_ff};
   assign quo_next = {quo_ff[PWM_W-2:0], trial_ge};
   assign sw_on    = next_pwm_ff > low_pwm_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      countdown_in  = countdown_ff;
      held_in       = held_ff;
      switch_in     = switch_ff;
      temp_in       = temp_ff;
      mask_in       = mask_ff;
      best_in       = best_ff;
      poll_in       = poll_ff;
      next_pwm_in   = next_pwm_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      acc_in        = acc_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_polled_in = rsp_polled_ff;
      rsp_pwm_in    = rsp_pwm_ff;
      rsp_switch_in = rsp_switch_ff;
      rsp_pchg_in   = rsp_pchg_ff;
      rsp_schg_in   = rsp_schg_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               temp_in[0] = req_bus.temp_a;
               temp_in[1] = req_bus.temp_b;
               temp_in[2] = req_bus.temp_c;
               temp_in[3] = req_bus.temp_d;
               mask_in    = req_bus.valid_mask;
               best_in    = '0;
               step_in    = '0;
               if (countdown_ff <= PERIOD_W'(1)) begin
                  state_in = ST_SCAN;
               end else begin
                  countdown_in = countdown_ff - PERIOD_W'(1);
                  poll_in      = 1'b0;
                  state_in     = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            // readings shift down, one compare per cycle
            if (mask_ff[0] && (temp_ff[0] > best_ff)) begin
               best_in = temp_ff[0];
            end
            for (int i = 0; i < FIELD_SENSORS - 1; i++) begin
               temp_in[i] = temp_ff[i+1];
            end
            mask_in = mask_ff >> 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == SCAN_LAST) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            poll_in = 1'b1;
            step_in = '0;
            if (best_ff <= low_temp_ff) begin
               next_pwm_in  = low_pwm_ff;
               countdown_in = heatup_ff;
               state_in     = ST_DONE;
            end else if (best_ff >= hi_temp) begin
               next_pwm_in  = hi_pwm;
               countdown_in = cooldown_ff;
               state_in     = ST_DONE;
            end else begin
               mcand_in     = best_ff - low_temp_ff;
               mplier_in    = hi_pwm - low_pwm_ff;
               div_in       = hi_temp - low_temp_ff;
               acc_in       = '0;
               countdown_in = fading_ff;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in    = acc_next;
            mplier_in = mplier_ff << 1;
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == BIT_LAST) begin
               // quotient fits in PWM_W bits, so the upper product bits start below the divisor
               rem_in   = acc_next[PROD_W-1:PWM_W];
               quo_in   = acc_next[PWM_W-1:0];
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = trial_ge ? TEMP_W'(trial - {1'b0, div_ff}) : trial[TEMP_W-1:0];
            quo_in  = quo_next;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == BIT_LAST) begin
               next_pwm_in = low_pwm_ff + quo_next;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_polled_in = poll_ff;
               rsp_pchg_in   = 1'b0;
               rsp_schg_in   = 1'b0;
               // same PWM leaves the switch alone
               if (poll_ff && (next_pwm_ff != held_ff)) begin
                  held_in     = next_pwm_ff;
                  rsp_pchg_in = 1'b1;
                  if (sw_on != switch_ff) begin
                     switch_in   = sw_on;
                     rsp_schg_in = 1'b1;
                  end
               end
               rsp_pwm_in    = held_in;
               rsp_switch_in = switch_in;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         countdown_ff <= HEATUP_RST;
         held_ff      <= '0;
         switch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         countdown_ff <= countdown_in;
         held_ff      <= held_in;
         switch_ff    <= switch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      temp_ff       <= temp_in;
      mask_ff       <= mask_in;
      best_ff       <= best_in;
      poll_ff       <= poll_in;
      next_pwm_ff   <= next_pwm_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      acc_ff        <= acc_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_polled_ff <= rsp_polled_in;
      rsp_pwm_ff    <= rsp_pwm_in;
      rsp_switch_ff <= rsp_switch_in;
      rsp_pchg_ff   <= rsp_pchg_in;
      rsp_schg_ff   <= rsp_schg_in;
   end

   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.polled         = rsp_polled_ff;
   assign rsp_bus.pwm_out        = rsp_pwm_ff;
   assign rsp_bus.switch_on      = rsp_switch_ff;
   assign rsp_bus.pwm_changed    = rsp_pchg_ff;
   assign rsp_bus.switch_changed = rsp_schg_ff;

   // ---------------- assertions ----------------
   a_one_tick_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("tick accepted while previous tick still in work");

   a_no_poll_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.polled) |-> (!rsp_bus.pwm_changed && !rsp_bus.switch_changed))
      else $error("change flag set on a tick that did not poll");

   a_switch_implies_pwm: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.switch_changed) |-> rsp_bus.pwm_changed)
      else $error("switch flipped without a PWM update");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("divide remainder not below divisor");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the temperature to PWM fader: directed table, then random ticks.
module testbench;
   import tpf_pkg::*;

   // Sensors the block scans; the predictor uses the same count.
   localparam int SENSORS = NUM_SENSORS_DEF;

   // No handshake for this many cycles ends the run as a failure.  The slowest tick is a
   // fading poll plus long receiver stalls, so this is ample.
   localparam int QUIET_LIMIT = 2000;

   // Cycles left after the last result before a register write, and at the very end.
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 40;

   // Random part: three idling phases, each made of a few register settings.
   localparam int PHASES        = 3;
   localparam int SETTINGS_EACH = 4;
   localparam int TICKS_EACH    = 51;
   localparam int TAIL_TICKS    = 12;

   localparam int PLAN_ROWS = 26;

   // One input beat: four readings and the mask that says which of them count.
   typedef struct packed {
      logic [TEMP_W-1:0] temp_a;
      logic [TEMP_W-1:0] temp_b;
      logic [TEMP_W-1:0] temp_c;
      logic [TEMP_W-1:0] temp_d;
      logic [MASK_W-1:0] valid_mask;
   } tick_type;

   // One result beat.
   typedef struct packed {
      logic             polled;
      logic [PWM_W-1:0] pwm_out;
      logic             switch_on;
      logic             pwm_changed;
      logic             switch_changed;
   } fade_res_type;

   // A result typed into the table travels with its tick up to acceptance.
   typedef struct packed {
      logic         typed;
      fade_res_type res;
   } typed_res_type;

   typedef enum logic [0:0] {
      ROW_TICK,
      ROW_CSR
   } row_kind_type;

   // A row of the directed table: a tick (sent reps times) or one register write.
   typedef struct packed {
      row_kind_type          kind;
      logic [3:0]            reps;
      tick_type              tick;
      logic                  typed;
      fade_res_type          res;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
   } row_type;

   localparam tick_type     NO_TICK = '0;
   localparam fade_res_type IDLE_RES = '0;

   // Directed plan.  The reset countdown of 15 is run down first, the periods are then
   // zeroed so every tick polls, and the limits are inverted and then widened to full span.
   localparam row_type PLAN [PLAN_ROWS] = '{
      // after reset: no poll, nothing held
      '{ROW_TICK, 4'd1, '{14'd0, 14'd0, 14'd0, 14'd0, 4'h0}, 1'b1,
        '{1'b0, 8'd0, 1'b0, 1'b0, 1'b0}, CSR_LOW_TEMP, 16'd0},
      // all readings at the top, still counting down to the first poll
      '{ROW_TICK, 4'd13, '{14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff, 4'hf}, 1'b1,
        '{1'b0, 8'd0, 1'b0, 1'b0, 1'b0}, CSR_LOW_TEMP, 16'd0},
      // zero periods: every following tick polls
      '{ROW_CSR, 4'd1, NO_TICK, 1'b0, IDLE_RES, CSR_HEATUP, 16'd0},
      '{ROW_CSR, 4'd1, NO_TICK, 1'b0, IDLE_RES, CSR_COOLDOWN, 16'd0},
      '{ROW_CSR, 4'd1, NO_TICK, 1'b0, IDLE_RES, CSR_FADING, 16'd0},
      // hot readings but none valid: taken as zero, PWM stays at minimum
      '{ROW_TICK, 4'd1, '{14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff, 4'h0}, 1'b1,
        '{1'b1, 8'd0, 1'b0, 1'b0, 1'b0}, CSR_LOW_TEMP, 16'd0},
      // top reading: full PWM, switch flips on
      '{ROW_TICK, 4'd1, '{14'h3fff, 14'd0, 14'd0, 14'd0, 4'h1}, 1'b1,
        '{1'b1, 8'd255, 1'b1, 1'b1, 1'b1}, CSR_LOW_TEMP, 16'd0},
      // exactly the high temperature: same PWM, no change flags
      '{ROW_TICK, 4'd1, '{14'h3fff, 14'd2400, 14'd0, 14'd0, 4'h2}, 1'b1,
        '{1'b1, 8'd255, 1'b1, 1'b0, 1'b0}, CSR_LOW_TEMP, 16'd0},
      // mid fade
      '{ROW_TICK, 4'd1, '{14'd0, 14'd0, 14'd1600, 14'd0, 4'h4}, 1'b0,
        IDLE_RES, CSR_LOW_TEMP, 16'd0},
      // just above low: truncates to minimum, switch flips off
      '{ROW_TICK, 4'd1, '{14'h3fff, 14'h3fff, 14'h3fff, 14'd801, 4'h8}, 1'b0,
        IDLE_RES, CSR_LOW_TEMP, 16'd0},
      // exactly the low temperature
      '{ROW_TICK, 4'd1, '{14'd800, 14'd0, 14'd0, 14'd800, 4'hf}, 1'b0,
        IDLE_RES, CSR_LOW_TEMP, 16'd0},
      // just below high: one step short of full
      '{ROW_TICK, 4'd1, '{14'd0, 14'd1, 14'd2399, 14'd5, 4'hf}, 1'b0,
        IDLE_RES, CSR_LOW_TEMP, 16'd0},
      // inverted limits at the extremes
      '{ROW_CSR, 4'd1, NO_TICK, 1'b0, IDLE_RES, CSR_LOW_TEMP, 16'h3fff},
      '{ROW_CSR, 4'd1, NO_TICK, 1'b0, IDLE_RES, CSR_HIGH_TEMP, 16'd0},
      '{ROW_CSR, 4'd1, NO_TICK, 1'b0, IDLE_RES, CSR_LOW_PWM, 16'd255},
      '{ROW_CSR, 4'd1, NO_TICK, 1'b0, IDLE_RES, CSR_HIGH_PWM, 16'd0},
      '{ROW_TICK, 4'd1, '{14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff, 4'hf}, 1'b0,
        IDLE_RES, CSR_LOW_TEMP, 16'd0},
      '{ROW_TICK, 4'd1, '{14'd0, 14'd0, 14'd0, 14'd0, 4'h0}, 1'b0,
        IDLE_RES, CSR_LOW_TEMP, 16'd0},
      // full-span window
      '{ROW_CSR, 4'd1, NO_TICK, 1'b0, IDLE_RES, CSR_LOW_TEMP, 16'd0},
      '{ROW_CSR, 4'd1, NO_TICK, 1'b0, IDLE_RES, CSR_HIGH_TEMP, 16'h3fff},
      '{ROW_CSR, 4'd1, NO_TICK, 1'b0, IDLE_RES, CSR_LOW_PWM, 16'd0},
      '{ROW_CSR, 4'd1, NO_TICK, 1'b0, IDLE_RES, CSR_HIGH_PWM, 16'd255},
      // same PWM as held: switch is not re-evaluated and stays off
      '{ROW_TICK, 4'd1, '{14'h3fff, 14'd0, 14'd0, 14'd0, 4'h1}, 1'b0,
        IDLE_RES, CSR_LOW_TEMP, 16'd0},
      '{ROW_TICK, 4'd1, '{14'd1, 14'd0, 14'd0, 14'd0, 4'h1}, 1'b0,
        IDLE_RES, CSR_LOW_TEMP, 16'd0},
      '{ROW_TICK, 4'd1, '{14'd0, 14'h2aaa, 14'h1555, 14'd0, 4'h6}, 1'b0,
        IDLE_RES, CSR_LOW_TEMP, 16'd0},
      '{ROW_TICK, 4'd1, '{14'd0, 14'h3ffe, 14'd0, 14'd0, 4'h2}, 1'b0,
        IDLE_RES, CSR_LOW_TEMP, 16'd0}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tpf_req_if req_bus ();
   tpf_rsp_if rsp_bus ();

   temperature_to_pwm_fader #(
      .NUM_SENSORS(SENSORS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Predictor copy of the registers, as last written.
   logic [TEMP_W-1:0]   low_temp_r  = LOW_TEMP_RST;
   logic [TEMP_W-1:0]   high_temp_r = HIGH_TEMP_RST;
   logic [PWM_W-1:0]    low_pwm_r   = LOW_PWM_RST;
   logic [PWM_W-1:0]    high_pwm_r  = HIGH_PWM_RST;
   logic [PERIOD_W-1:0] heatup_r    = HEATUP_RST;
   logic [PERIOD_W-1:0] cooldown_r  = COOLDOWN_RST;
   logic [PERIOD_W-1:0] fading_r    = FADING_RST;

   // Predictor copy of the block's state.
   logic [PERIOD_W-1:0] poll_countdown = HEATUP_RST;
   logic [PWM_W-1:0]    pwm_held       = '0;
   logic                fan_on         = 1'b0;

   fade_res_type  pending_fades [$];   // results owed by the block, oldest first
   typed_res_type typed_q [$];         // one entry per tick driven, consumed at acceptance

   int send_gap_pct  = 20;
   int rsp_stall_pct = 73;
   int quiet_cycles  = 0;
   int mismatches    = 0;
   int ticks_taken   = 0;
   int polls_seen    = 0;
   int pwm_moves     = 0;
   int switch_flips  = 0;
   int csr_writes    = 0;

   // Next result of the fader for one tick; advances the predictor state.
   function automatic fade_res_type predict_fade(input tick_type tk);
      logic [TEMP_W-1:0] reading [FIELD_SENSORS];
      logic [TEMP_W-1:0] hottest;
      logic [TEMP_W-1:0] top_temp;
      logic [PWM_W-1:0]  top_pwm;
      logic [PWM_W-1:0]  next_pwm;
      logic [PROD_W-1:0] num;
      logic [PROD_W-1:0] den;
      logic              want_on;
      fade_res_type      r;
      reading = '{tk.temp_a, tk.temp_b, tk.temp_c, tk.temp_d};
      r = '0;
      if (poll_countdown <= 1) begin
         hottest = '0;
         for (int i = 0; i < FIELD_SENSORS && i < SENSORS; i++) begin
            if (tk.valid_mask[i] && reading[i] > hottest)
               hottest = reading[i];
         end
         // inverted limits collapse onto the low values
         top_temp = (high_temp_r < low_temp_r) ? low_temp_r : high_temp_r;
         top_pwm  = (high_pwm_r < low_pwm_r) ? low_pwm_r : high_pwm_r;
         r.polled = 1'b1;
         if (hottest <= low_temp_r) begin
            next_pwm       = low_pwm_r;
            poll_countdown = heatup_r;
         end else if (hottest >= top_temp) begin
            next_pwm       = top_pwm;
            poll_countdown = cooldown_r;
         end else begin
            num = (PROD_W'(hottest) - PROD_W'(low_temp_r)) *
                  (PROD_W'(top_pwm) - PROD_W'(low_pwm_r));
            den = PROD_W'(top_temp) - PROD_W'(low_temp_r);
            next_pwm       = low_pwm_r + PWM_W'(num / den);
            poll_countdown = fading_r;
         end
         // switch only re-evaluated when the PWM actually moves
         if (next_pwm != pwm_held) begin
            want_on = (next_pwm > low_pwm_r);
            if (want_on != fan_on) begin
               fan_on           = want_on;
               r.switch_changed = 1'b1;
            end
            pwm_held      = next_pwm;
            r.pwm_changed = 1'b1;
         end
      end else begin
         poll_countdown = poll_countdown - 1'b1;
      end
      r.pwm_out   = pwm_held;
      r.switch_on = fan_on;
      return r;
   endfunction

   // Random readings, mostly around the current fade window so all three branches occur.
   function automatic tick_type random_tick();
      int lo;
      int hi;
      int v [FIELD_SENSORS];
      lo = int'(low_temp_r);
      hi = (high_temp_r < low_temp_r) ? int'(low_temp_r) : int'(high_temp_r);
      for (int i = 0; i < FIELD_SENSORS; i++) begin
         case ($urandom_range(0, 5))
            0: v[i] = $urandom_range(0, 16383);
            1: v[i] = lo + $urandom_range(0, 4) - 2;
            2: v[i] = hi + $urandom_range(0, 4) - 2;
            3: v[i] = $urandom_range(0, 1) ? 16383 : 0;
            default: v[i] = $urandom_range(lo, hi);
         endcase
         if (v[i] < 0)
            v[i] = 0;
         if (v[i] > 16383)
            v[i] = 16383;
      end
      return '{TEMP_W'(v[0]), TEMP_W'(v[1]), TEMP_W'(v[2]), TEMP_W'(v[3]),
               MASK_W'($urandom_range(0, 15))};
   endfunction

   // Present one tick and return at the edge that accepts it; random sender gaps first.
   task automatic drive_tick(input tick_type tk, input logic typed, input fade_res_type res);
      typed_res_type entry;
      entry   = '{typed, res};
      typed_q = {typed_q, entry};
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid      <= 1'b0;
         req_bus.temp_a     <= TEMP_W'($urandom);
         req_bus.temp_b     <= TEMP_W'($urandom);
         req_bus.temp_c     <= TEMP_W'($urandom);
         req_bus.temp_d     <= TEMP_W'($urandom);
         req_bus.valid_mask <= MASK_W'($urandom);
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.temp_a     <= tk.temp_a;
      req_bus.temp_b     <= tk.temp_b;
      req_bus.temp_c     <= tk.temp_c;
      req_bus.temp_d     <= tk.temp_d;
      req_bus.valid_mask <= tk.valid_mask;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // Hold off the sender until every owed result has been taken.
   task automatic wait_fades_out();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_fades.size() != 0)
         @(posedge clock);
   endtask

   // Register write, only with the block idle; the predictor copy follows the write.
   task automatic set_register(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] val);
      wait_fades_out();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_LOW_TEMP:  low_temp_r  = val[TEMP_W-1:0];
         CSR_HIGH_TEMP: high_temp_r = val[TEMP_W-1:0];
         CSR_LOW_PWM:   low_pwm_r   = val[PWM_W-1:0];
         CSR_HIGH_PWM:  high_pwm_r  = val[PWM_W-1:0];
         CSR_HEATUP:    heatup_r    = val;
         CSR_COOLDOWN:  cooldown_r  = val;
         CSR_FADING:    fading_r    = val;
         default: ;
      endcase
      csr_writes++;
      csr_we <= 1'b0;
   endtask

   always #5 clock = ~clock;

   // Receiver stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Checker: result beats are compared first, since a tick accepted at this edge can
   // never own a result leaving at the same edge.  Then the accepted tick is predicted.
   always @(posedge clock) begin
      fade_res_type  got;
      fade_res_type  want;
      typed_res_type pin;
      tick_type      tk;
      logic          moved;
      moved = 1'b0;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         moved = 1'b1;
         got = '{rsp_bus.polled, rsp_bus.pwm_out, rsp_bus.switch_on,
                 rsp_bus.pwm_changed, rsp_bus.switch_changed};
         if (pending_fades.size() == 0) begin
            $error("result beat with no tick waiting for it");
            mismatches++;
         end else begin
            want = pending_fades.pop_front();
            if (got.polled !== want.polled) begin
               $error("polled: expected %0d, got %0d", want.polled, got.polled);
               mismatches++;
            end
            if (got.pwm_out !== want.pwm_out) begin
               $error("pwm_out: expected %0d, got %0d", want.pwm_out, got.pwm_out);
               mismatches++;
            end
            if (got.switch_on !== want.switch_on) begin
               $error("switch_on: expected %0d, got %0d", want.switch_on, got.switch_on);
               mismatches++;
            end
            if (got.pwm_changed !== want.pwm_changed) begin
               $error("pwm_changed: expected %0d, got %0d",
                      want.pwm_changed, got.pwm_changed);
               mismatches++;
            end
            if (got.switch_changed !== want.switch_changed) begin
               $error("switch_changed: expected %0d, got %0d",
                      want.switch_changed, got.switch_changed);
               mismatches++;
            end
            polls_seen   += int'(want.polled);
            pwm_moves    += int'(want.pwm_changed);
            switch_flips += int'(want.switch_changed);
         end
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         moved = 1'b1;
         tk = '{req_bus.temp_a, req_bus.temp_b, req_bus.temp_c, req_bus.temp_d,
                req_bus.valid_mask};
         want = predict_fade(tk);
         // table rows with a typed result are checked against that value instead
         if (typed_q.size() != 0) begin
            pin = typed_q.pop_front();
            if (pin.typed)
               want = pin.res;
         end
         pending_fades = {pending_fades, want};
         ticks_taken++;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   // Watchdog: too long without any beat moving.
   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int      lt;
      int      ht;
      int      lp;
      int      hp;
      row_type row;

      clock              = 1'b0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.temp_a     = '0;
      req_bus.temp_b     = '0;
      req_bus.temp_c     = '0;
      req_bus.temp_d     = '0;
      req_bus.valid_mask = '0;
      rsp_bus.ready      = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table under the first idling phase.
      for (int i = 0; i < PLAN_ROWS; i++) begin
         row = PLAN[i];
         if (row.kind == ROW_CSR) begin
            set_register(row.csr_idx, row.csr_val);
         end else begin
            repeat (row.reps) drive_tick(row.tick, row.typed, row.res);
         end
      end

      // Random part: sender 20% / receiver 73%, then swapped, then no idling at all.
      for (int ph = 0; ph < PHASES; ph++) begin
         send_gap_pct  = (ph == 0) ? 20 : (ph == 1) ? 73 : 0;
         rsp_stall_pct = (ph == 0) ? 73 : (ph == 1) ? 20 : 0;
         for (int s = 0; s < SETTINGS_EACH; s++) begin
            // new fade window; sometimes empty or inverted, periods kept short
            lt = ($urandom_range(0, 5) == 0) ? 0 :
                 ($urandom_range(0, 5) == 0) ? 16383 : $urandom_range(0, 12000);
            case ($urandom_range(0, 7))
               0: ht = $urandom_range(0, lt);
               1: ht = lt;
               2: ht = 16383;
               default: ht = lt + $urandom_range(1, 4000);
            endcase
            if (ht > 16383)
               ht = 16383;
            lp = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
            case ($urandom_range(0, 5))
               0: hp = $urandom_range(0, lp);
               1: hp = 255;
               default: hp = $urandom_range(lp, 255);
            endcase
            set_register(CSR_LOW_TEMP, CSR_DATA_W'(lt));
            set_register(CSR_HIGH_TEMP, CSR_DATA_W'(ht));
            set_register(CSR_LOW_PWM, CSR_DATA_W'(lp));
            set_register(CSR_HIGH_PWM, CSR_DATA_W'(hp));
            set_register(CSR_HEATUP, CSR_DATA_W'(($urandom_range(0, 9) == 0) ?
                                     $urandom_range(4, 10) : $urandom_range(0, 2)));
            set_register(CSR_COOLDOWN, CSR_DATA_W'(($urandom_range(0, 9) == 0) ?
                                       $urandom_range(4, 10) : $urandom_range(0, 2)));
            set_register(CSR_FADING, CSR_DATA_W'(($urandom_range(0, 9) == 0) ?
                                     $urandom_range(4, 10) : $urandom_range(0, 2)));
            for (int n = 0; n < TICKS_EACH; n++) begin
               // now and then the sender holds until the block has fully drained
               if ($urandom_range(0, 49) == 0)
                  wait_fades_out();
               drive_tick(random_tick(), 1'b0, IDLE_RES);
            end
         end
      end

      // Longest periods: the next poll reloads 65535 and the rest just count down.
      set_register(CSR_HEATUP, 16'hffff);
      set_register(CSR_COOLDOWN, 16'hffff);
      set_register(CSR_FADING, 16'hffff);
      repeat (TAIL_TICKS) drive_tick(random_tick(), 1'b0, IDLE_RES);

      wait_fades_out();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_fades.size() != 0) begin
         $error("%0d results never arrived", pending_fades.size());
         mismatches += pending_fades.size();
      end

      $display("Ran %0d ticks, %0d of them polls, through %0d register writes.",
               ticks_taken, polls_seen, csr_writes);
      $display("Saw %0d PWM updates and %0d switch flips under three idling patterns.",
               pwm_moves, switch_flips);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
